@@ rtl/core/hsfc_pkg.sv @@
`default_nettype none
package hsfc_pkg;

  // Frame store depth; the write index saturates here.
  localparam int BUFFER_DEPTH = 32;
  localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);

  // Only the header, payload and checksum positions are ever read back.
  localparam int HDR_BYTES = 8;

  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 11;
  localparam int RX_SUM_W    = 16;
  localparam int FRAME_LEN_W = 6;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_I    = 8'h49;
  localparam logic [BYTE_W-1:0] CH_F    = 8'h46;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;

  typedef logic [HDR_BYTES-1:0][BYTE_W-1:0] hsfc_view_t;

  // Frame state -> result stage
  typedef struct packed {
    logic                   emit;
    logic [FRAME_LEN_W-1:0] length;
  } hsfc_hit_t;

endpackage
`default_nettype wire

@@ rtl/core/hsfc_frame_state.sv @@
`default_nettype none
module hsfc_frame_state
  import hsfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] byte_in,
  output hsfc_view_t             view,
  output hsfc_hit_t              hit
);

  logic [BYTE_W-1:0] hdr [HDR_BYTES];
  logic [IDX_W-1:0]  widx;
  logic [BYTE_W-1:0] prev;

  logic             is_restart;
  logic             is_star;
  logic             room;
  logic [IDX_W-1:0] widx_after;

  // Decode the incoming word against the current state
  always_comb begin
    is_restart = ((byte_in == CH_I) || (byte_in == CH_F)) && (prev == CH_HASH);
    is_star    = (byte_in == CH_STAR) && !is_restart;
    room       = widx < IDX_W'(BUFFER_DEPTH);
    widx_after = room ? widx + IDX_W'(1) : widx;
  end

  // Header bytes as seen after this word is stored
  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      view[k] = (room && (widx == IDX_W'(k))) ? byte_in : hdr[k];
    end
  end

  always_comb begin
    hit.emit   = is_star && (view[0] == CH_HASH) && (view[1] == CH_I);
    hit.length = FRAME_LEN_W'(widx_after);
  end

  // State update; bytes past the header window are never read, so not kept
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HDR_BYTES; k++) hdr[k] <= '0;
      widx <= '0;
      prev <= '0;
    end else if (step) begin
      prev <= byte_in;
      if (is_restart) begin
        hdr[0] <= CH_HASH;
        hdr[1] <= byte_in;
        widx   <= IDX_W'(2);
      end else begin
        for (int k = 0; k < HDR_BYTES; k++) begin
          if (room && (widx == IDX_W'(k))) hdr[k] <= byte_in;
        end
        widx <= is_star ? '0 : widx_after;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hsfc_result.sv @@
`default_nettype none
module hsfc_result
  import hsfc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  hsfc_view_t                   view,
  input  hsfc_hit_t                    hit,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic [BYTE_W-1:0]            payload_0,
  output logic [BYTE_W-1:0]            payload_1,
  output logic [BYTE_W-1:0]            payload_2,
  output logic [BYTE_W-1:0]            payload_3,
  output logic [SUM_W-1:0]             computed_sum,
  output logic [RX_SUM_W-1:0]          received_sum,
  output logic                         sum_ok,
  output logic [FRAME_LEN_W-1:0]       frame_length
);

  logic [SUM_W-1:0]    sum_next;
  logic [RX_SUM_W-1:0] rx_next;

  // Checksum over type byte and four payload bytes
  always_comb begin
    sum_next = SUM_W'(view[1]) + SUM_W'(view[2]) + SUM_W'(view[3])
             + SUM_W'(view[4]) + SUM_W'(view[5]);
    rx_next  = {view[6], view[7]};
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= hit.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && hit.emit) begin
      payload_0    <= view[2];
      payload_1    <= view[3];
      payload_2    <= view[4];
      payload_3    <= view[5];
      computed_sum <= sum_next;
      received_sum <= rx_next;
      sum_ok       <= rx_next == RX_SUM_W'(sum_next);
      frame_length <= hit.length;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hash_star_frame_checker_core.sv @@
// Channel | Signals                                   | Dir | Word
// in      | in_valid, in_stall, rx_byte               | in  | one received byte
// out     | out_valid, out_stall, payload_0..3,       | out | one checked '#I...*' frame
//         | computed_sum, received_sum, sum_ok,       |     |
//         | frame_length                              |     |
//
// One byte per cycle while in_stall is low; a frame result is valid once its star is taken
// and has passed the input register, then the result register; later while the result slot is held.
// Frame state is updated as a byte leaves the input register.
// rst is synchronous and clears header bytes, write index, previous byte and valids.
// in_stall rises only while a result is held under out_stall and a byte is waiting.
`default_nettype none
module hash_star_frame_checker_core
  import hsfc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [BYTE_W-1:0]      rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [BYTE_W-1:0]           payload_0,
  output logic [BYTE_W-1:0]           payload_1,
  output logic [BYTE_W-1:0]           payload_2,
  output logic [BYTE_W-1:0]           payload_3,
  output logic [SUM_W-1:0]            computed_sum,
  output logic [RX_SUM_W-1:0]         received_sum,
  output logic                        sum_ok,
  output logic [FRAME_LEN_W-1:0]      frame_length
);

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              step;
  hsfc_view_t        view;
  hsfc_hit_t         hit;

  // Byte moves on whenever the result slot frees up this edge
  always_comb begin
    advance  = !out_valid || !out_stall;
    step     = in_full && advance;
    in_stall = in_full && !advance;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte <= rx_byte;
  end

  hsfc_frame_state u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (in_byte),
    .view    (view),
    .hit     (hit)
  );

  hsfc_result u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .view         (view),
    .hit          (hit),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .payload_0    (payload_0),
    .payload_1    (payload_1),
    .payload_2    (payload_2),
    .payload_3    (payload_3),
    .computed_sum (computed_sum),
    .received_sum (received_sum),
    .sum_ok       (sum_ok),
    .frame_length (frame_length)
  );

endmodule
`default_nettype wire

@@ rtl/core/hsfc_checker.sv @@
`default_nettype none
module hsfc_checker
  import hsfc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SUM_W-1:0]       computed_sum,
  input wire logic [RX_SUM_W-1:0]    received_sum,
  input wire logic                   sum_ok,
  input wire logic [FRAME_LEN_W-1:0] frame_length
);

  // A held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out word dropped while stalled");

  // Match flag agrees with the two sums
  a_sum_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sum_ok == (received_sum == RX_SUM_W'(computed_sum))))
    else $error("sum_ok disagrees with sums");

  // Header plus star is at least three bytes, never past the store
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_length >= FRAME_LEN_W'(3)) &&
                  (frame_length <= FRAME_LEN_W'(BUFFER_DEPTH)))
    else $error("frame_length out of range");

  // Input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind hash_star_frame_checker_core hsfc_checker u_hsfc_checker (.*);
`default_nettype wire
